/* src/spr_pkg.sv */
// Shared constants, types and the CRC-32 byte update for the SLIP packet receiver.
package spr_pkg;

    localparam int PAYLOAD_MAX = 1024;
    localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);
    localparam int IDX_W       = 10;
    localparam int OUT_LEN_W   = 11;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
    localparam logic [7:0] START_0      = 8'h58;
    localparam logic [7:0] START_1      = 8'h52;

    localparam logic [15:0] HEADER_OVERHEAD = 16'd8;
    localparam logic [16:0] TOTAL_MAX       = 17'(PAYLOAD_MAX + 8);

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef enum logic [3:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TYPE,
        PH_FLAGS,
        PH_ID_HI,
        PH_ID_LO,
        PH_DATA,
        PH_CRC0,
        PH_CRC1,
        PH_CRC2,
        PH_CRC3
    } phase_t;

    typedef struct packed {
        logic                 payload_valid;
        logic [7:0]           payload_byte;
        logic [IDX_W-1:0]     payload_index;
        logic                 frame_done;
        logic                 crc_good;
        logic [7:0]           packet_type;
        logic [7:0]           packet_flags;
        logic [15:0]          packet_id;
        logic [OUT_LEN_W-1:0] payload_length;
        logic [15:0]          crc_fail_count;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* src/slip_framed_packet_receiver.sv */
// Top level of the SLIP packet receiver: input register, parser, result register.
//
// Usage:
//   Input channel rx_valid/rx_ready/rx_byte carries one raw link byte per
//   request. Every accepted byte gives exactly one result request on the
//   result_valid/result_ready channel, carrying the payload byte (when
//   payload_valid), frame_done/crc_good on the last CRC byte, the held
//   header fields and the saturating CRC failure count.
//   A byte accepted into the input register is parsed combinationally and
//   its result is loaded into the result register when that has space.
//   Throughput: one byte per cycle while result_ready keeps up; the CRC-32
//   byte update and the parser step are combinational between the registers.
//   A stalled result holds in the result register; the input register still
//   takes one more byte, after which rx_ready falls until result_ready
//   returns.
//   Reset (rst_n low) empties both registers and returns the parser to
//   hunting for the start bytes, CRC to all ones and counters to zero.
module slip_framed_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [9:0]  payload_index,
    output logic        frame_done,
    output logic        crc_good,
    output logic [7:0]  packet_type,
    output logic [7:0]  packet_flags,
    output logic [15:0] packet_id,
    output logic [10:0] payload_length,
    output logic [15:0] crc_fail_count
);

    logic             in_full;
    logic [7:0]       in_byte;
    logic             out_space;
    logic             advance;
    spr_pkg::result_t res_d;
    spr_pkg::result_t res_q;

    assign advance = in_full && out_space;

    spr_input_stage u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .full     (in_full),
        .byte_q   (in_byte)
    );

    spr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte),
        .result  (res_d)
    );

    spr_output_stage u_output (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .d            (res_d),
        .space        (out_space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .q            (res_q)
    );

    assign payload_valid  = res_q.payload_valid;
    assign payload_byte   = res_q.payload_byte;
    assign payload_index  = res_q.payload_index;
    assign frame_done     = res_q.frame_done;
    assign crc_good       = res_q.crc_good;
    assign packet_type    = res_q.packet_type;
    assign packet_flags   = res_q.packet_flags;
    assign packet_id      = res_q.packet_id;
    assign payload_length = res_q.payload_length;
    assign crc_fail_count = res_q.crc_fail_count;

endmodule

/* src/spr_input_stage.sv */
// Input register holding one received byte until the parser takes it.
module spr_input_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       full,
    output logic [7:0] byte_q
);

    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;

    assign rx_ready  = !full_reg || advance;
    assign full_next = (rx_valid && rx_ready) || (full_reg && !advance);
    assign full      = full_reg;
    assign byte_q    = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

/* src/spr_parser.sv */
// SLIP unescaping, frame parser, CRC-32 check and failure counter.
module spr_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       byte_in,
    output spr_pkg::result_t result
);

    spr_pkg::phase_t            phase_reg, phase_next;
    logic                       esc_reg, esc_next;
    logic [31:0]                crc_reg, crc_next;
    logic [23:0]                rcrc_reg, rcrc_next;
    logic [spr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [7:0]                 type_reg, type_next;
    logic [7:0]                 flags_reg, flags_next;
    logic [15:0]                id_reg, id_next;
    logic [spr_pkg::LEN_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]                fail_reg, fail_next;
    logic [7:0]                 len_hi_reg, len_hi_next;

    logic [7:0]  c;
    logic        use_byte;
    logic [15:0] total;
    logic [31:0] crc_upd;
    logic [31:0] rcrc_full;
    logic [spr_pkg::LEN_W-1:0] cnt_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= spr_pkg::PH_HUNT0;
            esc_reg    <= 1'b0;
            crc_reg    <= spr_pkg::CRC_INIT;
            rcrc_reg   <= '0;
            len_reg    <= '0;
            type_reg   <= '0;
            flags_reg  <= '0;
            id_reg     <= '0;
            cnt_reg    <= '0;
            fail_reg   <= '0;
            len_hi_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            crc_reg    <= crc_next;
            rcrc_reg   <= rcrc_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            flags_reg  <= flags_next;
            id_reg     <= id_next;
            cnt_reg    <= cnt_next;
            fail_reg   <= fail_next;
            len_hi_reg <= len_hi_next;
        end
    end

    assign total     = {len_hi_reg, c};
    assign crc_upd   = spr_pkg::crc_byte(crc_reg, c);
    assign rcrc_full = {rcrc_reg, c};
    assign cnt_inc   = cnt_reg + spr_pkg::LEN_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        flags_next  = flags_reg;
        id_next     = id_reg;
        cnt_next    = cnt_reg;
        fail_next   = fail_reg;
        len_hi_next = len_hi_reg;
        c           = byte_in;
        use_byte    = 1'b1;
        result      = '0;

        // unescape
        if (!esc_reg)
        begin
            if (byte_in == spr_pkg::SLIP_END)
            begin
                phase_next = spr_pkg::PH_HUNT0;
                use_byte   = 1'b0;
            end
            else if (byte_in == spr_pkg::SLIP_ESC)
            begin
                esc_next = 1'b1;
                use_byte = 1'b0;
            end
        end
        else
        begin
            esc_next = 1'b0;
            if (byte_in == spr_pkg::SLIP_ESC_END)
            begin
                c = spr_pkg::SLIP_END;
            end
            else if (byte_in == spr_pkg::SLIP_ESC_ESC)
            begin
                c = spr_pkg::SLIP_ESC;
            end
            else
            begin
                use_byte = 1'b0;
            end
        end

        if (use_byte)
        begin
            case (phase_reg)
                spr_pkg::PH_HUNT1:
                begin
                    if (c == spr_pkg::START_1)
                    begin
                        crc_next   = spr_pkg::CRC_INIT;
                        phase_next = spr_pkg::PH_LEN_HI;
                    end
                    else
                    begin
                        phase_next = spr_pkg::PH_HUNT0;
                    end
                end
                spr_pkg::PH_LEN_HI:
                begin
                    len_hi_next = c;
                    crc_next    = crc_upd;
                    phase_next  = spr_pkg::PH_LEN_LO;
                end
                spr_pkg::PH_LEN_LO:
                begin
                    crc_next = crc_upd;
                    if (total < spr_pkg::HEADER_OVERHEAD || {1'b0, total} > spr_pkg::TOTAL_MAX)
                    begin
                        phase_next = spr_pkg::PH_HUNT0;
                    end
                    else
                    begin
                        len_next   = spr_pkg::LEN_W'(total - spr_pkg::HEADER_OVERHEAD);
                        phase_next = spr_pkg::PH_TYPE;
                    end
                end
                spr_pkg::PH_TYPE:
                begin
                    type_next  = c;
                    crc_next   = crc_upd;
                    phase_next = spr_pkg::PH_FLAGS;
                end
                spr_pkg::PH_FLAGS:
                begin
                    flags_next = c;
                    crc_next   = crc_upd;
                    phase_next = spr_pkg::PH_ID_HI;
                end
                spr_pkg::PH_ID_HI:
                begin
                    id_next    = {c, 8'd0};
                    crc_next   = crc_upd;
                    phase_next = spr_pkg::PH_ID_LO;
                end
                spr_pkg::PH_ID_LO:
                begin
                    id_next    = {id_reg[15:8], c};
                    crc_next   = crc_upd;
                    cnt_next   = '0;
                    phase_next = (len_reg != '0) ? spr_pkg::PH_DATA : spr_pkg::PH_CRC0;
                end
                spr_pkg::PH_DATA:
                begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = c;
                    result.payload_index = cnt_reg[spr_pkg::IDX_W-1:0];
                    crc_next             = crc_upd;
                    cnt_next             = cnt_inc;
                    if (cnt_inc >= len_reg)
                    begin
                        phase_next = spr_pkg::PH_CRC0;
                    end
                end
                spr_pkg::PH_CRC0:
                begin
                    rcrc_next  = {16'd0, c};
                    phase_next = spr_pkg::PH_CRC1;
                end
                spr_pkg::PH_CRC1:
                begin
                    rcrc_next  = {8'd0, rcrc_reg[7:0], c};
                    phase_next = spr_pkg::PH_CRC2;
                end
                spr_pkg::PH_CRC2:
                begin
                    rcrc_next  = {rcrc_reg[15:0], c};
                    phase_next = spr_pkg::PH_CRC3;
                end
                spr_pkg::PH_CRC3:
                begin
                    phase_next        = spr_pkg::PH_HUNT0;
                    result.frame_done = 1'b1;
                    if (rcrc_full == ~crc_reg)
                    begin
                        result.crc_good = 1'b1;
                    end
                    else if (fail_reg != 16'hFFFF)
                    begin
                        fail_next = fail_reg + 16'd1;
                    end
                end
                default:
                begin
                    phase_next = (c == spr_pkg::START_0) ? spr_pkg::PH_HUNT1 : spr_pkg::PH_HUNT0;
                end
            endcase
        end

        result.packet_type    = type_next;
        result.packet_flags   = flags_next;
        result.packet_id      = id_next;
        result.payload_length = spr_pkg::OUT_LEN_W'(len_next);
        result.crc_fail_count = fail_next;
    end

endmodule

/* src/spr_output_stage.sv */
// Result register holding one result until the downstream side takes it.
module spr_output_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  spr_pkg::result_t d,
    output logic             space,
    output logic             result_valid,
    input  logic             result_ready,
    output spr_pkg::result_t q
);

    logic             full_reg;
    logic             full_next;
    spr_pkg::result_t data_reg;

    assign space        = !full_reg || result_ready;
    assign full_next    = load || (full_reg && !result_ready);
    assign result_valid = full_reg;
    assign q            = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= d;
        end
    end

endmodule
